// ----- hdl/plpit_pkg.sv -----
// ----------------------------------------------------------------------------
// plpit_pkg: shared types and constants for the polyline pair intersect test
// Default sizes, tolerance width, cell pipeline depth, control state
// encoding, the control word that travels along the cell row and the compare width.
// ----------------------------------------------------------------------------
package plpit_pkg;

  // default sizes
  localparam int MAX_VERTICES_DEF = 64;
  localparam int COORD_WIDTH_DEF  = 24;

  // collinear tolerance register width
  localparam int TOL_WIDTH = 50;

  // register stages inside one cell after its query register, up to and including its hit register
  localparam int CELL_STAGES = 4;

  // top level control states
  typedef enum logic {
    ST_RUN,
    ST_DRAIN
  } state_t;

  // control word handed from one cell to the next
  typedef struct packed {
    logic q_valid;  // query segment present in the query register
    logic hit;      // some cell upstream found a meeting pair
  } chain_ctl_t;

  // width of the signed compare between a cross product and the tolerance bounds
  function automatic int cmp_width(input int coord_width);
    int dw;
    dw = 2 * coord_width + 3;
    return (dw > TOL_WIDTH + 1) ? dw : TOL_WIDTH + 1;
  endfunction

endpackage

// ----- hdl/polyline_pair_intersect_test.sv -----
// Input: a vertex without last is accepted in the cycle it is offered; the
// result of a pair is shown once the row has drained after its last vertex.
// Throughput: one vertex per cycle, except that after a last vertex input
// stalls while the row drains (longer while the previous result is not
// taken), set by the query walking the MAX_VERTICES-cell row plus the 4-stage cell test.
// Reset: synchronous, clears the store and flags, collinear tolerance to 1.
// ----------------------------------------------------------------------------
// polyline_pair_intersect_test: do two polylines meet anywhere
// First-polyline vertices shift into a row of cells; each second-polyline
// segment walks down the row and is tested against every stored segment.
// The last vertex drains the row, gives one result and clears the pair.
// ----------------------------------------------------------------------------
module polyline_pair_intersect_test #(
  parameter int MAX_VERTICES = plpit_pkg::MAX_VERTICES_DEF,
  parameter int COORD_WIDTH  = plpit_pkg::COORD_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  // configuration
  input  logic                                cfg_wr_en,
  input  logic [plpit_pkg::TOL_WIDTH-1:0]     cfg_wr_data,
  // vertex transactions
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                which_line,
  input  logic signed [COORD_WIDTH-1:0]       vertex_x,
  input  logic signed [COORD_WIDTH-1:0]       vertex_y,
  input  logic                                last,
  // result transactions
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                intersects,
  output logic                                overflow,
  output logic                                order_error
);

  localparam int CMP_W     = plpit_pkg::cmp_width(COORD_WIDTH);
  localparam int CNT_W     = $clog2(MAX_VERTICES + 1);
  localparam int DRAIN_LEN = MAX_VERTICES + plpit_pkg::CELL_STAGES;
  localparam int DRAIN_W   = $clog2(DRAIN_LEN + 1);

  plpit_pkg::state_t state, state_next;
  logic [DRAIN_W-1:0] drain_cnt, drain_cnt_next;
  logic               do_result;

  logic signed [CMP_W-1:0] tol_hi, tol_lo;

  logic [CNT_W-1:0]              count;
  logic                          have_prev;
  logic signed [COORD_WIDTH-1:0] prev_x, prev_y;
  logic                          found, ovf_flag, ord_flag;

  logic accept, full, store, issue, chain_out;

  // row links: vertex shift path and query chain
  logic signed [COORD_WIDTH-1:0] sx [MAX_VERTICES+2];
  logic signed [COORD_WIDTH-1:0] sy [MAX_VERTICES+2];
  logic                          sl [MAX_VERTICES+2];
  plpit_pkg::chain_ctl_t         ctl [MAX_VERTICES+1];
  logic signed [COORD_WIDTH-1:0] q1x [MAX_VERTICES+1];
  logic signed [COORD_WIDTH-1:0] q1y [MAX_VERTICES+1];
  logic signed [COORD_WIDTH-1:0] q2x [MAX_VERTICES+1];
  logic signed [COORD_WIDTH-1:0] q2y [MAX_VERTICES+1];

  assign accept = in_valid && in_ready;
  assign full   = (count == CNT_W'(MAX_VERTICES));
  assign store  = accept && !which_line && !have_prev && !full;
  assign issue  = accept && which_line && have_prev;

  // control state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= plpit_pkg::ST_RUN;
      drain_cnt <= '0;
    end else begin
      state     <= state_next;
      drain_cnt <= drain_cnt_next;
    end
  end

  // next state: run takes vertices, drain waits for the row to empty
  always_comb begin
    state_next     = state;
    drain_cnt_next = drain_cnt;
    do_result      = 1'b0;
    in_ready       = 1'b0;
    unique case (state)
      plpit_pkg::ST_RUN: begin
        in_ready = 1'b1;
        if (in_valid && last) begin
          state_next     = plpit_pkg::ST_DRAIN;
          drain_cnt_next = DRAIN_W'(DRAIN_LEN);
        end
      end
      plpit_pkg::ST_DRAIN: begin
        if (drain_cnt != '0) begin
          drain_cnt_next = drain_cnt - 1'b1;
        end else if (!out_valid || out_ready) begin
          do_result  = 1'b1;
          state_next = plpit_pkg::ST_RUN;
        end
      end
    endcase
  end

  // tolerance as open signed bounds
  always_ff @(posedge clk) begin
    if (rst) begin
      tol_hi <= CMP_W'(1);
      tol_lo <= '1;
    end else if (cfg_wr_en) begin
      tol_hi <= CMP_W'(cfg_wr_data);
      tol_lo <= CMP_W'(0) - CMP_W'(cfg_wr_data);
    end
  end

  // pair bookkeeping and result register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      have_prev <= 1'b0;
      found     <= 1'b0;
      ovf_flag  <= 1'b0;
      ord_flag  <= 1'b0;
      out_valid <= 1'b0;
    end else if (do_result) begin
      count     <= '0;
      have_prev <= 1'b0;
      found     <= 1'b0;
      ovf_flag  <= 1'b0;
      ord_flag  <= 1'b0;
      out_valid <= 1'b1;
    end else begin
      found <= found | chain_out;
      if (accept && !which_line) begin
        if (have_prev) begin
          ord_flag <= 1'b1;
        end else if (full) begin
          ovf_flag <= 1'b1;
        end else begin
          count <= count + 1'b1;
        end
      end
      if (accept && which_line) begin
        have_prev <= 1'b1;
      end
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // previous second-polyline vertex
  always_ff @(posedge clk) begin
    if (accept && which_line) begin
      prev_x <= vertex_x;
      prev_y <= vertex_y;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (do_result) begin
      intersects  <= found | chain_out;
      overflow    <= ovf_flag;
      order_error <= ord_flag;
    end
  end

  // row ends
  assign sx[0] = vertex_x;
  assign sy[0] = vertex_y;
  assign sl[0] = 1'b1;
  assign sx[MAX_VERTICES+1] = '0;
  assign sy[MAX_VERTICES+1] = '0;
  assign sl[MAX_VERTICES+1] = 1'b0;

  assign ctl[0].q_valid = issue;
  assign ctl[0].hit     = 1'b0;
  assign q1x[0] = prev_x;
  assign q1y[0] = prev_y;
  assign q2x[0] = vertex_x;
  assign q2y[0] = vertex_y;

  assign chain_out = ctl[MAX_VERTICES].hit;

  // row of cells
  for (genvar i = 0; i < MAX_VERTICES; i++) begin : g_cell
    plpit_cell #(
      .COORD_WIDTH(COORD_WIDTH)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .clear    (do_result),
      .shift_en (store),
      .up_x     (sx[i]),
      .up_y     (sy[i]),
      .up_loaded(sl[i]),
      .vert_x   (sx[i+1]),
      .vert_y   (sy[i+1]),
      .loaded   (sl[i+1]),
      .nb_x     (sx[i+2]),
      .nb_y     (sy[i+2]),
      .nb_loaded(sl[i+2]),
      .ctl_in   (ctl[i]),
      .q1x_in   (q1x[i]),
      .q1y_in   (q1y[i]),
      .q2x_in   (q2x[i]),
      .q2y_in   (q2y[i]),
      .ctl_out  (ctl[i+1]),
      .q1x_out  (q1x[i+1]),
      .q1y_out  (q1y[i+1]),
      .q2x_out  (q2x[i+1]),
      .q2y_out  (q2y[i+1]),
      .tol_hi   (tol_hi),
      .tol_lo   (tol_lo)
    );
  end

endmodule

// ----- hdl/plpit_cell.sv -----
// ----------------------------------------------------------------------------
// plpit_cell: one cell of the segment test row
// Holds one first-polyline vertex; together with its neighbor's vertex it
// forms one stored segment. A query segment moves through the row one cell
// per cycle; each cell tests it against its own segment in a four-stage
// pipeline and ORs its hit into the hit chain.
// ----------------------------------------------------------------------------
module plpit_cell #(
  parameter int COORD_WIDTH = plpit_pkg::COORD_WIDTH_DEF
) (
  input  logic                                               clk,
  input  logic                                               rst,
  input  logic                                               clear,
  input  logic                                               shift_en,
  // vertex shifting in from the upstream side
  input  logic signed [COORD_WIDTH-1:0]                      up_x,
  input  logic signed [COORD_WIDTH-1:0]                      up_y,
  input  logic                                               up_loaded,
  // vertex held here
  output logic signed [COORD_WIDTH-1:0]                      vert_x,
  output logic signed [COORD_WIDTH-1:0]                      vert_y,
  output logic                                               loaded,
  // neighbor vertex closing this cell's segment
  input  logic signed [COORD_WIDTH-1:0]                      nb_x,
  input  logic signed [COORD_WIDTH-1:0]                      nb_y,
  input  logic                                               nb_loaded,
  // query segment chain
  input  plpit_pkg::chain_ctl_t                              ctl_in,
  input  logic signed [COORD_WIDTH-1:0]                      q1x_in,
  input  logic signed [COORD_WIDTH-1:0]                      q1y_in,
  input  logic signed [COORD_WIDTH-1:0]                      q2x_in,
  input  logic signed [COORD_WIDTH-1:0]                      q2y_in,
  output plpit_pkg::chain_ctl_t                              ctl_out,
  output logic signed [COORD_WIDTH-1:0]                      q1x_out,
  output logic signed [COORD_WIDTH-1:0]                      q1y_out,
  output logic signed [COORD_WIDTH-1:0]                      q2x_out,
  output logic signed [COORD_WIDTH-1:0]                      q2y_out,
  // open tolerance bounds: -tol < d < tol counts as collinear
  input  logic signed [plpit_pkg::cmp_width(COORD_WIDTH)-1:0] tol_hi,
  input  logic signed [plpit_pkg::cmp_width(COORD_WIDTH)-1:0] tol_lo
);

  localparam int DIFF_W = COORD_WIDTH + 1;
  localparam int PROD_W = 2 * COORD_WIDTH + 2;
  localparam int CROSS_W = 2 * COORD_WIDTH + 3;
  localparam int CMP_W = plpit_pkg::cmp_width(COORD_WIDTH);

  // query register
  logic                          qv;
  logic signed [COORD_WIDTH-1:0] q1x, q1y, q2x, q2y;

  // stage 1: coordinate differences and bounding box flags
  logic                     v1;
  logic signed [DIFF_W-1:0] fa [4];
  logic signed [DIFF_W-1:0] fb [4];
  logic signed [DIFF_W-1:0] ga [4];
  logic signed [DIFF_W-1:0] gb [4];
  logic [3:0]               box1;

  // stage 2: products
  logic                     v2;
  logic signed [PROD_W-1:0] ma [4];
  logic signed [PROD_W-1:0] mb [4];
  logic [3:0]               box2;

  // stage 3: cross products
  logic                      v3;
  logic signed [CROSS_W-1:0] cr [4];
  logic [3:0]                box3;

  // stage 4: hit and hit chain
  logic hit;
  logic hit_acc;
  logic hit_next;
  logic seg_ok;

  function automatic logic signed [DIFF_W-1:0] sub(
    input logic signed [COORD_WIDTH-1:0] a,
    input logic signed [COORD_WIDTH-1:0] b
  );
    return DIFF_W'(a) - DIFF_W'(b);
  endfunction

  // point p inside the box spanned by a and b, edges included
  function automatic logic in_box(
    input logic signed [COORD_WIDTH-1:0] ax,
    input logic signed [COORD_WIDTH-1:0] ay,
    input logic signed [COORD_WIDTH-1:0] px,
    input logic signed [COORD_WIDTH-1:0] py,
    input logic signed [COORD_WIDTH-1:0] bx,
    input logic signed [COORD_WIDTH-1:0] by
  );
    logic in_x, in_y;
    in_x = (px >= ax && px <= bx) || (px >= bx && px <= ax);
    in_y = (py >= ay && py <= by) || (py >= by && py <= ay);
    return in_x && in_y;
  endfunction

  assign seg_ok = loaded && nb_loaded;

  // stored vertex, shifts toward the far end on every store
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      loaded <= 1'b0;
    end else if (shift_en) begin
      loaded <= up_loaded;
    end
  end

  always_ff @(posedge clk) begin
    if (shift_en) begin
      vert_x <= up_x;
      vert_y <= up_y;
    end
  end

  // query register, reloaded every cycle from upstream
  always_ff @(posedge clk) begin
    if (rst) begin
      qv <= 1'b0;
    end else begin
      qv <= ctl_in.q_valid;
    end
  end

  always_ff @(posedge clk) begin
    q1x <= q1x_in;
    q1y <= q1y_in;
    q2x <= q2x_in;
    q2y <= q2y_in;
  end

  // stage valid bits and hit chain
  always_ff @(posedge clk) begin
    if (rst) begin
      v1      <= 1'b0;
      v2      <= 1'b0;
      v3      <= 1'b0;
      hit     <= 1'b0;
      hit_acc <= 1'b0;
    end else begin
      v1      <= qv && seg_ok;
      v2      <= v1;
      v3      <= v2;
      hit     <= hit_next;
      hit_acc <= ctl_in.hit | hit;
    end
  end

  // stage 1: differences for the four cross products, p1 here, p2 at neighbor
  always_ff @(posedge clk) begin
    // query side against p1
    fa[0] <= sub(q2x, q1x);
    fb[0] <= sub(vert_y, q2y);
    ga[0] <= sub(q2y, q1y);
    gb[0] <= sub(vert_x, q2x);
    // query side against p2
    fa[1] <= sub(q2x, q1x);
    fb[1] <= sub(nb_y, q2y);
    ga[1] <= sub(q2y, q1y);
    gb[1] <= sub(nb_x, q2x);
    // stored side against q1
    fa[2] <= sub(nb_x, vert_x);
    fb[2] <= sub(q1y, nb_y);
    ga[2] <= sub(nb_y, vert_y);
    gb[2] <= sub(q1x, nb_x);
    // stored side against q2
    fa[3] <= sub(nb_x, vert_x);
    fb[3] <= sub(q2y, nb_y);
    ga[3] <= sub(nb_y, vert_y);
    gb[3] <= sub(q2x, nb_x);
    box1[0] <= in_box(q1x, q1y, vert_x, vert_y, q2x, q2y);
    box1[1] <= in_box(q1x, q1y, nb_x, nb_y, q2x, q2y);
    box1[2] <= in_box(vert_x, vert_y, q1x, q1y, nb_x, nb_y);
    box1[3] <= in_box(vert_x, vert_y, q2x, q2y, nb_x, nb_y);
  end

  // stage 2: eight products in parallel
  always_ff @(posedge clk) begin
    for (int k = 0; k < 4; k++) begin
      ma[k] <= PROD_W'(fa[k]) * PROD_W'(fb[k]);
      mb[k] <= PROD_W'(ga[k]) * PROD_W'(gb[k]);
    end
    box2 <= box1;
  end

  // stage 3: cross products
  always_ff @(posedge clk) begin
    for (int k = 0; k < 4; k++) begin
      cr[k] <= CROSS_W'(ma[k]) - CROSS_W'(mb[k]);
    end
    box3 <= box2;
  end

  // stage 4: proper crossing or near-collinear touch
  always_comb begin
    logic [3:0] pos, neg, near;
    logic signed [CMP_W-1:0] cx;
    for (int k = 0; k < 4; k++) begin
      cx      = CMP_W'(cr[k]);
      pos[k]  = cr[k] > 0;
      neg[k]  = cr[k] < 0;
      near[k] = (cx > tol_lo) && (cx < tol_hi);
    end
    hit_next = v3 && ((((pos[0] && neg[1]) || (neg[0] && pos[1])) &&
                       ((pos[2] && neg[3]) || (neg[2] && pos[3]))) ||
                      (|(near & box3)));
  end

  assign ctl_out.q_valid = qv;
  assign ctl_out.hit     = hit_acc;
  assign q1x_out = q1x;
  assign q1y_out = q1y;
  assign q2x_out = q2x;
  assign q2y_out = q2y;

endmodule

// ----- hdl/plpit_checker.sv -----
// ----------------------------------------------------------------------------
// plpit_checker: port-level checks for the polyline pair intersect test
// Watches the handshake ports of the top level; attached by bind.
// ----------------------------------------------------------------------------
module plpit_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic last,
  input logic out_valid,
  input logic out_ready,
  input logic intersects,
  input logic overflow,
  input logic order_error
);

  // a waiting result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable({intersects, overflow, order_error}))
    else $error("result changed while stalled");

  // a last vertex closes the input as the row starts to drain
  a_last_stall: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && last |=> !in_ready)
    else $error("input open right after last transaction");

  // a new result only comes out of a drain
  a_result_after_drain: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result without preceding drain");

  // reset leaves the block empty and ready
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("block not idle after reset");

endmodule

bind polyline_pair_intersect_test plpit_checker u_plpit_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .last       (last),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .intersects (intersects),
  .overflow   (overflow),
  .order_error(order_error)
);
